@@ rtl/flr_pkg.sv @@
// ----------------------------------------------------------------------------
// flr_pkg
// Types, codes and checksum helpers shared by the log record writer modules.
// ----------------------------------------------------------------------------
package flr_pkg;

  typedef enum logic [1:0] {
    KIND_BEGIN  = 2'd0,
    KIND_CHECK  = 2'd1,
    KIND_APPEND = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    OP_ERASE    = 2'd0,
    OP_PROGRAM  = 2'd1,
    OP_VERDICT  = 2'd2,
    OP_RECOVERY = 2'd3
  } op_e;

  localparam logic CfgRegionStart = 1'b0;
  localparam logic CfgRegionEnd   = 1'b1;

  localparam logic [31:0] LogMagic    = 32'h5345_4E53;
  localparam logic [31:0] StartReset  = 32'h080E_0000;
  localparam logic [31:0] EndReset    = 32'h0810_0000;
  localparam logic [31:0] RecordBytes = 32'd16;
  localparam logic [15:0] CrcInit     = 16'hFFFF;
  localparam logic [15:0] CrcPoly     = 16'h1021;

  // Bytes of a record after the magic word: time, x, y, z, motion, ok, led.
  localparam int TailBytes = 10;
  localparam int CrcStages = TailBytes / 2;

  typedef struct packed {
    logic [1:0]        kind;
    logic [31:0]       magic_word;
    logic [31:0]       time_ms;
    logic signed [7:0] accel_x;
    logic signed [7:0] accel_y;
    logic signed [7:0] accel_z;
    logic [7:0]        motion_flag;
    logic [7:0]        sensor_ok_flag;
    logic [7:0]        led_flag;
    logic [15:0]       stored_crc;
  } in_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] address;
    logic [31:0] word_data;
    logic        last;
  } out_t;

  // One record in flight through the checksum pipeline.
  typedef struct packed {
    logic [1:0]            kind;
    logic                  magic_ok;
    logic [8*TailBytes-1:0] msg;
    logic [15:0]           stored_crc;
    logic [15:0]           crc;
  } stage_t;

  // Classified item handed from the front to the back.
  typedef struct packed {
    logic [1:0]  kind;
    logic        rec_ok;
    logic [31:0] word1;
    logic [31:0] word2;
    logic [31:0] word3;
  } entry_t;

  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

  function automatic logic [15:0] crc_pair(logic [15:0] crc, logic [7:0] b0,
                                           logic [7:0] b1);
    return crc_byte(crc_byte(crc, b0), b1);
  endfunction

  // Checksum state after the four magic bytes; only records carrying the
  // magic word can pass, so the first word never needs hardware.
  localparam logic [15:0] CrcMagic =
    crc_pair(crc_pair(CrcInit, LogMagic[7:0], LogMagic[15:8]),
             LogMagic[23:16], LogMagic[31:24]);

endpackage

@@ rtl/flr_front.sv @@
// ----------------------------------------------------------------------------
// flr_front
// Accepts items and runs the record checksum over two bytes per stage.
// ----------------------------------------------------------------------------
module flr_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  flr_pkg::in_t    in_data_i,
  output logic            q_valid_o,
  input  logic            q_ready_i,
  output flr_pkg::entry_t q_entry_o
);

  localparam int N = flr_pkg::CrcStages;

  flr_pkg::stage_t in_stage;
  flr_pkg::stage_t src   [N];
  flr_pkg::stage_t nxt   [N];
  flr_pkg::stage_t st_q  [N];
  logic [N-1:0]    v_q;
  logic [N-1:0]    adv;

  always_comb begin
    in_stage.kind       = in_data_i.kind;
    in_stage.magic_ok   = (in_data_i.magic_word == flr_pkg::LogMagic);
    in_stage.msg        = {in_data_i.led_flag, in_data_i.sensor_ok_flag,
                           in_data_i.motion_flag, in_data_i.accel_z,
                           in_data_i.accel_y, in_data_i.accel_x, in_data_i.time_ms};
    in_stage.stored_crc = in_data_i.stored_crc;
    in_stage.crc        = flr_pkg::CrcMagic;
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      src[i]     = (i == 0) ? in_stage : st_q[(i == 0) ? 0 : i - 1];
      nxt[i]     = src[i];
      nxt[i].crc = flr_pkg::crc_pair(src[i].crc, src[i].msg[16*i +: 8],
                                     src[i].msg[16*i+8 +: 8]);
    end
  end

  // A stage moves when it is empty or its successor moves.
  always_comb begin
    adv[N-1] = !v_q[N-1] || q_ready_i;
    for (int i = N - 2; i >= 0; i--) begin
      adv[i] = !v_q[i] || adv[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int i = 0; i < N; i++) begin
        if (adv[i]) begin
          v_q[i] <= (i == 0) ? in_valid_i : v_q[(i == 0) ? 0 : i - 1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < N; i++) begin
      if (adv[i]) begin
        st_q[i] <= nxt[i];
      end
    end
  end

  assign in_ready_o = adv[0];
  assign q_valid_o  = v_q[N-1];

  always_comb begin
    q_entry_o.kind   = st_q[N-1].kind;
    q_entry_o.rec_ok = st_q[N-1].magic_ok && (st_q[N-1].crc == st_q[N-1].stored_crc);
    q_entry_o.word1  = st_q[N-1].msg[31:0];
    q_entry_o.word2  = st_q[N-1].msg[63:32];
    q_entry_o.word3  = {st_q[N-1].crc, st_q[N-1].msg[79:64]};
  end

endmodule

@@ rtl/flr_queue.sv @@
// ----------------------------------------------------------------------------
// flr_queue
// Short register queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module flr_queue #(
  parameter int Depth = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  flr_pkg::entry_t entry_i,
  output logic            full_o,
  output logic            head_valid_o,
  output flr_pkg::entry_t head_o,
  input  logic            pop_i
);

  localparam int IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  flr_pkg::entry_t mem_q [Depth];
  logic [IdxW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            wr, rd;

  assign full_o       = (cnt_q == CntW'(Depth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_q];
  assign wr           = push_i && !full_o;
  assign rd           = pop_i && head_valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (wr) begin
      wr_d = (wr_q == IdxW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (rd) begin
      rd_d = (rd_q == IdxW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (wr && !rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd && !wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

@@ rtl/flr_back.sv @@
// ----------------------------------------------------------------------------
// flr_back
// Carries out queued items and owns the write pointer and the recovery flag;
// issues one result per cycle into the output register while it has room.
// ----------------------------------------------------------------------------
module flr_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            head_valid_i,
  input  flr_pkg::entry_t head_i,
  output logic            pop_o,
  input  logic [31:0]     region_start_i,
  input  logic [31:0]     region_end_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output flr_pkg::out_t   out_data_o
);

  logic [31:0]   wp_q, wp_d;
  logic          rec_q, rec_d;
  logic          erased_q, erased_d;
  logic [1:0]    idx_q, idx_d;
  logic          out_valid_q, out_valid_d;
  flr_pkg::out_t out_q, out_d;

  logic          room, fits, emit, ok;
  logic [31:0]   wp_next;
  logic [31:0]   word;
  flr_pkg::out_t res;

  assign room    = !out_valid_q || out_ready_i;
  assign fits    = ({1'b0, wp_q} + 33'(flr_pkg::RecordBytes)) <= {1'b0, region_end_i};
  assign wp_next = wp_q + flr_pkg::RecordBytes;
  assign ok      = rec_q && fits && head_i.rec_ok;

  always_comb begin
    case (idx_q)
      2'd0:    word = flr_pkg::LogMagic;
      2'd1:    word = head_i.word1;
      2'd2:    word = head_i.word2;
      default: word = head_i.word3;
    endcase
  end

  always_comb begin
    wp_d     = wp_q;
    rec_d    = rec_q;
    erased_d = erased_q;
    idx_d    = idx_q;
    pop_o    = 1'b0;
    emit     = 1'b0;
    res      = '0;
    if (head_valid_i && room) begin
      case (head_i.kind)
        flr_pkg::KIND_BEGIN: begin
          wp_d          = region_start_i;
          rec_d         = 1'b1;
          pop_o         = 1'b1;
          emit          = 1'b1;
          res.op        = flr_pkg::OP_RECOVERY;
          res.address   = region_start_i;
          res.last      = 1'b1;
        end
        flr_pkg::KIND_CHECK: begin
          pop_o         = 1'b1;
          emit          = 1'b1;
          res.op        = flr_pkg::OP_VERDICT;
          res.last      = 1'b1;
          res.word_data = {31'd0, ok};
          if (ok) begin
            wp_d        = wp_next;
            res.address = wp_next;
          end else begin
            rec_d       = 1'b0;
            res.address = wp_q;
          end
        end
        flr_pkg::KIND_APPEND: begin
          emit = 1'b1;
          if (!erased_q && idx_q == 2'd0 && !fits) begin
            // The record would run past the sector: erase and start over.
            wp_d        = region_start_i;
            erased_d    = 1'b1;
            res.op      = flr_pkg::OP_ERASE;
            res.address = region_start_i;
          end else begin
            res.op        = flr_pkg::OP_PROGRAM;
            res.address   = wp_q + {28'd0, idx_q, 2'b00};
            res.word_data = word;
            res.last      = (idx_q == 2'd3);
            idx_d         = idx_q + 1'b1;
            if (idx_q == 2'd3) begin
              wp_d     = wp_next;
              erased_d = 1'b0;
              pop_o    = 1'b1;
            end
          end
        end
        default: begin
          // An unused kind is dropped without a result.
          pop_o = 1'b1;
        end
      endcase
    end
    out_valid_d = emit ? 1'b1 : (out_valid_q && !out_ready_i);
    out_d       = emit ? res : out_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= flr_pkg::StartReset;
      rec_q       <= 1'b0;
      erased_q    <= 1'b0;
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      wp_q        <= wp_d;
      rec_q       <= rec_d;
      erased_q    <= erased_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/flash_log_record_writer.sv @@
// ----------------------------------------------------------------------------
// flash_log_record_writer
// Append-only flash log writer with checksummed records and recovery scan.
// ----------------------------------------------------------------------------
// Items enter on the in channel and results leave on the out channel, both
// valid/ready, one result per cycle while out_ready_i is high. Region bounds
// must be written on the cfg port while idle; the block does not enforce it.
// Each item passes a five-stage checksum pipeline, two record bytes per
// stage, then a short queue; the back end issues results from the queue
// head into an output register.
// The back end's single command slot handles one item at a time: an append
// issues four program words (after an erase when the record does not fit), a
// begin or a check one result, an unused kind no result. Items are accepted
// every cycle while the pipeline and queue have room.
// Reset sets the region to its default sector, the write pointer to the
// region start and clears recovery; no items are in flight afterwards.
// When the receiver stalls, the output register holds its result, the back
// end waits, the queue and then the pipeline fill, and in_ready_o falls.
// ----------------------------------------------------------------------------
module flash_log_record_writer #(
  parameter int QueueDepth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  flr_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output flr_pkg::out_t out_data_o,
  input  logic          cfg_we_i,
  input  logic          cfg_index_i,
  input  logic [31:0]   cfg_wdata_i
);

  logic [31:0]     region_start_q, region_end_q;
  logic            q_valid, q_full, head_valid, pop;
  flr_pkg::entry_t q_entry, head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_start_q <= flr_pkg::StartReset;
      region_end_q   <= flr_pkg::EndReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        flr_pkg::CfgRegionStart: region_start_q <= cfg_wdata_i;
        flr_pkg::CfgRegionEnd:   region_end_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  flr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_valid_o  (q_valid),
    .q_ready_i  (!q_full),
    .q_entry_o  (q_entry)
  );

  flr_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_valid),
    .entry_i      (q_entry),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  flr_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (head_valid),
    .head_i         (head),
    .pop_o          (pop),
    .region_start_i (region_start_q),
    .region_end_i   (region_end_q),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_data_o     (out_data_o)
  );

endmodule
